// ----- src/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define VCLI_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication check failed");

// condition that must never hold outside reset
`define VCLI_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");

`endif

// ----- src/vcli_pkg.sv -----
// types, constants and helpers of the colormap lookup pipeline
// no dependencies
`default_nettype none
package vcli_pkg;

  localparam int TABLE_DEPTH   = 64;
  localparam int FRACTION_BITS = 16;
  localparam int ADDR_W        = $clog2(TABLE_DEPTH);
  localparam int LAM_W         = FRACTION_BITS + 1;
  localparam int REM_W         = 32 + FRACTION_BITS;
  localparam int DIV_STAGES    = FRACTION_BITS + 2;
  localparam int ACC_W         = FRACTION_BITS + 10;
  localparam int LATENCY       = FRACTION_BITS + 8;
  localparam int CFG_IDX_W     = 4;

  // shifts between the Q16 sample scale and the internal lambda scale
  localparam int N_SHL = (FRACTION_BITS >= 16) ? FRACTION_BITS - 16 : 0;
  localparam int N_SHR = (FRACTION_BITS >= 16) ? 0 : 16 - FRACTION_BITS;

  localparam logic [LAM_W-1:0] LAM_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  typedef enum logic [1:0] {
    CMD_WR_COLOR = 2'd0,
    CMD_WR_ALPHA = 2'd1,
    CMD_MAP_RAW  = 2'd2,
    CMD_MAP_NORM = 2'd3
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_VALUE   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUE   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_COUNT = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_COUNT = 4'd3;

  typedef struct packed {
    logic [31:0] min_value;
    logic [31:0] max_value;
    logic [6:0]  color_count;
    logic [6:0]  alpha_count;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    cmd_t             cmd;
    logic [5:0]       index;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
    logic [LAM_W-1:0] lam_norm;
    logic             force_zero;
    logic             span_err;
  } item_t;

  // last entry in use, with out-of-range counts folded in
  function automatic logic [ADDR_W-1:0] last_entry(input logic [6:0] c);
    logic [ADDR_W-1:0] r;
    if (c == 7'd0) r = '0;
    else if (int'(c) > TABLE_DEPTH) r = ADDR_W'(TABLE_DEPTH - 1);
    else r = ADDR_W'(c - 7'd1);
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- src/vcli_ram.sv -----
// generic ram, one write port and two registered read ports
// no dependencies
`default_nettype none
module vcli_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  // write and registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a <= mem_r[raddr_a];
    rdata_b <= mem_r[raddr_b];
  end
endmodule
`default_nettype wire

// ----- src/vcli_front.sv -----
// front stages: span subtraction, sign handling and normalized-mode lambda
// depends on vcli_pkg
`default_nettype none
module vcli_front import vcli_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire item_t       in_item,
  input  wire logic [31:0] in_sample,
  input  wire cfg_t        cfg,
  output item_t            out_item,
  output logic [31:0]      out_num_abs,
  output logic [31:0]      out_den_abs
);
  item_t              s1_item_r, s2_item_r, s2_item_nxt, s3_item_r, s3_item_nxt;
  logic [31:0]        s1_sample_r;
  logic signed [32:0] num_r, num_nxt, den_r, den_nxt;
  logic [31:0]        an_r, an_nxt, ad_r, ad_nxt;
  logic [16:0]        n_clamp;
  logic [LAM_W+16:0]  n_wide;

  // capture the transfer
  always_ff @(posedge clk) begin
    s1_item_r   <= rst_n ? in_item : '0;
    s1_sample_r <= in_sample;
  end

  // differences and normalized lambda
  always_comb begin
    num_nxt = $signed({s1_sample_r[31], s1_sample_r}) -
              $signed({cfg.min_value[31], cfg.min_value});
    den_nxt = $signed({cfg.max_value[31], cfg.max_value}) -
              $signed({cfg.min_value[31], cfg.min_value});
    if (s1_sample_r[31]) n_clamp = '0;
    else if (s1_sample_r > 32'd65536) n_clamp = 17'd65536;
    else n_clamp = s1_sample_r[16:0];
    n_wide = ((LAM_W+17)'(n_clamp) << N_SHL) >> N_SHR;
    s2_item_nxt = s1_item_r;
    s2_item_nxt.lam_norm = LAM_W'(n_wide);
  end

  always_ff @(posedge clk) begin
    s2_item_r <= rst_n ? s2_item_nxt : '0;
    num_r     <= num_nxt;
    den_r     <= den_nxt;
  end

  // magnitudes and the zero cases
  always_comb begin
    an_nxt = num_r[32] ? 32'(-num_r) : num_r[31:0];
    ad_nxt = den_r[32] ? 32'(-den_r) : den_r[31:0];
    s3_item_nxt = s2_item_r;
    s3_item_nxt.span_err   = (s2_item_r.cmd == CMD_MAP_RAW) && (den_r == '0);
    s3_item_nxt.force_zero = (den_r == '0) || (num_r == '0) || (num_r[32] != den_r[32]);
  end

  always_ff @(posedge clk) begin
    s3_item_r <= rst_n ? s3_item_nxt : '0;
    an_r      <= an_nxt;
    ad_r      <= ad_nxt;
  end

  assign out_item    = s3_item_r;
  assign out_num_abs = an_r;
  assign out_den_abs = ad_r;
endmodule
`default_nettype wire

// ----- src/vcli_div.sv -----
// pipelined restoring divider, one quotient bit per stage after the entry stage
// depends on vcli_pkg
`default_nettype none
module vcli_div import vcli_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire item_t       in_item,
  input  wire logic [31:0] in_num_abs,
  input  wire logic [31:0] in_den_abs,
  output item_t            out_item,
  output logic [LAM_W-1:0] out_quo,
  output logic             out_sat
);
  item_t            item_r [DIV_STAGES];
  logic [REM_W-1:0] rem_r  [DIV_STAGES];
  logic [31:0]      den_r  [DIV_STAGES];
  logic [LAM_W-1:0] quo_r  [DIV_STAGES];
  logic             sat_r  [DIV_STAGES];

  // entry stage: scaled dividend and early saturation when quotient reaches two
  always_ff @(posedge clk) begin
    item_r[0] <= rst_n ? in_item : '0;
    rem_r[0]  <= REM_W'(in_num_abs) << FRACTION_BITS;
    den_r[0]  <= in_den_abs;
    quo_r[0]  <= '0;
    sat_r[0]  <= {1'b0, in_num_abs} >= {in_den_abs, 1'b0};
  end

  for (genvar k = 1; k < DIV_STAGES; k++) begin : g_stage
    localparam int J = FRACTION_BITS + 1 - k;
    logic [REM_W-1:0] sub;
    logic [REM_W-1:0] rem_nxt;
    logic [LAM_W-1:0] quo_nxt;

    // trial subtract of the divisor shifted to this bit
    always_comb begin
      sub     = REM_W'(den_r[k-1]) << J;
      rem_nxt = rem_r[k-1];
      quo_nxt = quo_r[k-1];
      if (rem_r[k-1] >= sub) begin
        rem_nxt    = rem_r[k-1] - sub;
        quo_nxt[J] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      item_r[k] <= rst_n ? item_r[k-1] : '0;
      rem_r[k]  <= rem_nxt;
      den_r[k]  <= den_r[k-1];
      quo_r[k]  <= quo_nxt;
      sat_r[k]  <= sat_r[k-1];
    end
  end

  assign out_item = item_r[DIV_STAGES-1];
  assign out_quo  = quo_r[DIV_STAGES-1];
  assign out_sat  = sat_r[DIV_STAGES-1];
endmodule
`default_nettype wire

// ----- src/vcli_back.sv -----
// back stages: lambda select, entry locate, table access and blend
// depends on vcli_pkg and vcli_ram
`default_nettype none
module vcli_back import vcli_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire item_t            in_item,
  input  wire logic [LAM_W-1:0] in_quo,
  input  wire logic             in_sat,
  input  wire cfg_t             cfg,
  output logic                  out_valid,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue,
  output logic [7:0]            out_alpha,
  output logic [16:0]           out_lambda_out,
  output logic                  out_span_error
);
  localparam int F_W = LAM_W + ADDR_W;

  logic [ADDR_W-1:0]        clast, alast;
  logic [LAM_W-1:0]         lam;
  item_t                    l1_item_r, l2_item_r;
  logic [LAM_W-1:0]         l1_lam_r, l2_lam_r;
  logic [F_W-1:0]           cf_r, cf_nxt, af_r, af_nxt;
  logic [ADDR_W:0]          cidx, aidx;
  logic [ADDR_W-1:0]        clo, chi, alo, ahi;
  logic [FRACTION_BITS-1:0] cfrac_r, afrac_r;
  logic                     cwe, awe;
  logic [23:0]              crd_lo, crd_hi;
  logic [7:0]               ard_lo, ard_hi;
  logic [LAM_W-1:0]         cw_lo, aw_lo;
  logic [ACC_W-1:0]         r_nxt, g_nxt, b_nxt, a_nxt;
  logic [ACC_W-1:0]         r_r, g_r, b_r, a_r;
  logic                     l3_valid_r, l3_err_r;
  logic [LAM_W-1:0]         l3_lam_r;
  logic [LAM_W+15:0]        lam_wide;

  assign clast = last_entry(cfg.color_count);
  assign alast = last_entry(cfg.alpha_count);

  // lambda select and scaling by the entry span
  always_comb begin
    if (in_item.cmd == CMD_MAP_NORM) lam = in_item.lam_norm;
    else if (in_item.force_zero) lam = '0;
    else if (in_sat || in_quo > LAM_ONE) lam = LAM_ONE;
    else lam = in_quo;
    cf_nxt = F_W'(lam) * F_W'(clast);
    af_nxt = F_W'(lam) * F_W'(alast);
  end

  always_ff @(posedge clk) begin
    l1_item_r <= rst_n ? in_item : '0;
    l1_lam_r  <= lam;
    cf_r      <= cf_nxt;
    af_r      <= af_nxt;
  end

  // entry indexes with the upper neighbour clamped to the last entry
  always_comb begin
    cidx = (ADDR_W+1)'(cf_r >> FRACTION_BITS);
    aidx = (ADDR_W+1)'(af_r >> FRACTION_BITS);
    clo  = (cidx > (ADDR_W+1)'(clast)) ? clast : cidx[ADDR_W-1:0];
    alo  = (aidx > (ADDR_W+1)'(alast)) ? alast : aidx[ADDR_W-1:0];
    chi  = (clo < clast) ? clo + 1'b1 : clo;
    ahi  = (alo < alast) ? alo + 1'b1 : alo;
    cwe  = l1_item_r.valid && (l1_item_r.cmd == CMD_WR_COLOR) &&
           (32'(l1_item_r.index) < TABLE_DEPTH);
    awe  = l1_item_r.valid && (l1_item_r.cmd == CMD_WR_ALPHA) &&
           (32'(l1_item_r.index) < TABLE_DEPTH);
  end

  vcli_ram #(.WIDTH(24), .DEPTH(TABLE_DEPTH)) u_color_ram (
    .clk     (clk),
    .we      (cwe),
    .waddr   (ADDR_W'(l1_item_r.index)),
    .wdata   ({l1_item_r.red, l1_item_r.green, l1_item_r.blue}),
    .raddr_a (clo),
    .raddr_b (chi),
    .rdata_a (crd_lo),
    .rdata_b (crd_hi)
  );

  vcli_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_alpha_ram (
    .clk     (clk),
    .we      (awe),
    .waddr   (ADDR_W'(l1_item_r.index)),
    .wdata   (l1_item_r.alpha),
    .raddr_a (alo),
    .raddr_b (ahi),
    .rdata_a (ard_lo),
    .rdata_b (ard_hi)
  );

  always_ff @(posedge clk) begin
    l2_item_r <= rst_n ? l1_item_r : '0;
    l2_lam_r  <= l1_lam_r;
    cfrac_r   <= cf_r[FRACTION_BITS-1:0];
    afrac_r   <= af_r[FRACTION_BITS-1:0];
  end

  // linear blend of the two neighbours per channel
  always_comb begin
    cw_lo = LAM_ONE - LAM_W'(cfrac_r);
    aw_lo = LAM_ONE - LAM_W'(afrac_r);
    r_nxt = ACC_W'(cw_lo) * ACC_W'(crd_lo[23:16]) +
            ACC_W'(cfrac_r) * ACC_W'(crd_hi[23:16]);
    g_nxt = ACC_W'(cw_lo) * ACC_W'(crd_lo[15:8]) +
            ACC_W'(cfrac_r) * ACC_W'(crd_hi[15:8]);
    b_nxt = ACC_W'(cw_lo) * ACC_W'(crd_lo[7:0]) +
            ACC_W'(cfrac_r) * ACC_W'(crd_hi[7:0]);
    a_nxt = ACC_W'(aw_lo) * ACC_W'(ard_lo) +
            ACC_W'(afrac_r) * ACC_W'(ard_hi);
  end

  always_ff @(posedge clk) begin
    r_r      <= r_nxt;
    g_r      <= g_nxt;
    b_r      <= b_nxt;
    a_r      <= a_nxt;
    l3_lam_r <= l2_lam_r;
    l3_err_r <= l2_item_r.span_err;
    if (!rst_n) l3_valid_r <= 1'b0;
    else l3_valid_r <= l2_item_r.valid &&
                       ((l2_item_r.cmd == CMD_MAP_RAW) || (l2_item_r.cmd == CMD_MAP_NORM));
  end

  // result ports, lambda brought back to the Q16 scale
  assign lam_wide       = ((LAM_W+16)'(l3_lam_r) << N_SHR) >> N_SHL;
  assign out_valid      = l3_valid_r;
  assign out_red        = r_r[FRACTION_BITS+7:FRACTION_BITS];
  assign out_green      = g_r[FRACTION_BITS+7:FRACTION_BITS];
  assign out_blue       = b_r[FRACTION_BITS+7:FRACTION_BITS];
  assign out_alpha      = a_r[FRACTION_BITS+7:FRACTION_BITS];
  assign out_lambda_out = 17'(lam_wide);
  assign out_span_error = l3_err_r;
endmodule
`default_nettype wire

// ----- src/value_to_color_lut_interpolate_unit.sv -----
// top level of the colormap lookup with linear interpolation
// depends on vcli_pkg, vcli_front, vcli_div, vcli_back
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  input    | start / busy       | command, sample, entry index, rgb, alpha
//  result   | out_valid strobe   | rgb, alpha, lambda, span error
//  config   | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// one transfer is taken every cycle; busy stays low
// a map result passes through three front stages, the one-bit-per-stage
// divider and three back stages
// loads write their table entry in pipeline order, so later maps see them
// synchronous active-low reset clears the valid bits and the config registers
// results last one cycle each; the receiver cannot hold them off
`default_nettype none
module value_to_color_lut_interpolate_unit import vcli_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           in_command,
  input  wire logic [31:0]          in_sample,
  input  wire logic [5:0]           in_entry_index,
  input  wire logic [7:0]           in_red,
  input  wire logic [7:0]           in_green,
  input  wire logic [7:0]           in_blue,
  input  wire logic [7:0]           in_alpha,
  output logic                      out_valid,
  output logic [7:0]                out_red,
  output logic [7:0]                out_green,
  output logic [7:0]                out_blue,
  output logic [7:0]                out_alpha,
  output logic [16:0]               out_lambda_out,
  output logic                      out_span_error,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);
  cfg_t             cfg_r;
  item_t            in_item, f_item, d_item;
  logic [31:0]      num_abs, den_abs;
  logic [LAM_W-1:0] quo;
  logic             sat;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_value   <= 32'd0;
      cfg_r.max_value   <= 32'd65536;
      cfg_r.color_count <= 7'd1;
      cfg_r.alpha_count <= 7'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MIN_VALUE:   cfg_r.min_value   <= cfg_data;
        REG_MAX_VALUE:   cfg_r.max_value   <= cfg_data;
        REG_COLOR_COUNT: cfg_r.color_count <= cfg_data[6:0];
        REG_ALPHA_COUNT: cfg_r.alpha_count <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // input transfer packed for the pipeline
  always_comb begin
    in_item            = '0;
    in_item.valid      = start && !busy;
    in_item.cmd        = cmd_t'(in_command);
    in_item.index      = in_entry_index;
    in_item.red        = in_red;
    in_item.green      = in_green;
    in_item.blue       = in_blue;
    in_item.alpha      = in_alpha;
  end

  vcli_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_item     (in_item),
    .in_sample   (in_sample),
    .cfg         (cfg_r),
    .out_item    (f_item),
    .out_num_abs (num_abs),
    .out_den_abs (den_abs)
  );

  vcli_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (f_item),
    .in_num_abs (num_abs),
    .in_den_abs (den_abs),
    .out_item   (d_item),
    .out_quo    (quo),
    .out_sat    (sat)
  );

  vcli_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_item        (d_item),
    .in_quo         (quo),
    .in_sat         (sat),
    .cfg            (cfg_r),
    .out_valid      (out_valid),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_alpha      (out_alpha),
    .out_lambda_out (out_lambda_out),
    .out_span_error (out_span_error)
  );
endmodule
`default_nettype wire

// ----- src/vcli_checker.sv -----
// port-level checks of the colormap lookup, bound to the top level
// depends on vcli_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module vcli_checker import vcli_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 start,
  input wire logic                 busy,
  input wire logic [1:0]           in_command,
  input wire logic                 out_valid,
  input wire logic [16:0]          out_lambda_out,
  input wire logic                 out_span_error
);
  logic map_xfer;

  // map transfer on the input channel
  assign map_xfer = start && !busy &&
                    (in_command == CMD_MAP_RAW || in_command == CMD_MAP_NORM);

  // a result only follows a map transfer at the fixed latency
  `VCLI_ASSERT_IMP(a_result_from_map, clk, rst_n, out_valid, $past(map_xfer, LATENCY))
  // span error only from a raw-mode map
  `VCLI_ASSERT_IMP(a_err_raw_only, clk, rst_n, out_valid && out_span_error, $past(in_command == CMD_MAP_RAW, LATENCY))
  // zero span gives lambda zero
  `VCLI_ASSERT_IMP(a_err_lambda_zero, clk, rst_n, out_valid && out_span_error, out_lambda_out == 17'd0)
  // lambda never beyond one
  `VCLI_ASSERT_NEVER(a_lambda_range, clk, rst_n, out_valid && (out_lambda_out > 17'd65536))
endmodule

bind value_to_color_lut_interpolate_unit vcli_checker u_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_command     (in_command),
  .out_valid      (out_valid),
  .out_lambda_out (out_lambda_out),
  .out_span_error (out_span_error)
);
`default_nettype wire

// ----- tb/testbench.sv -----
// self-checking testbench for the colormap lookup with linear interpolation
// depends on vcli_pkg and value_to_color_lut_interpolate_unit
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import vcli_pkg::*;

  typedef enum logic [1:0] {K_ITEM, K_CFG, K_DRAIN} step_kind_t;

  typedef struct {
    step_kind_t  kind;
    cmd_t        cmd;
    logic [31:0] sample;
    logic [5:0]  idx;
    logic [7:0]  red, green, blue, alpha;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [31:0] reg_data;
  } step_t;

  typedef struct packed {
    logic [7:0]  red, green, blue, alpha;
    logic [16:0] lambda;
    logic        span_err;
  } pixel_t;

  localparam int QUIET_NEED = LATENCY + 4;
  localparam int WATCHDOG   = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0]  in_command = '0;
  logic [31:0] in_sample = '0;
  logic [5:0]  in_entry_index = '0;
  logic [7:0]  in_red = '0, in_green = '0, in_blue = '0, in_alpha = '0;
  logic out_valid;
  logic [7:0]  out_red, out_green, out_blue, out_alpha;
  logic [16:0] out_lambda_out;
  logic out_span_error;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  step_t  pending[$];
  pixel_t pixels_due[$];

  // predictor state
  logic signed [31:0] p_min = 32'sd0, p_max = 32'sd65536;
  logic [6:0]  p_ccount = 7'd1, p_acount = 7'd1;
  logic [23:0] p_colors [TABLE_DEPTH];
  logic [7:0]  p_alphas [TABLE_DEPTH];

  int errors = 0, n_maps = 0, n_loads = 0, n_cfg = 0, n_span = 0;
  int quiet = 0, stall = 0, driven = 0;

  value_to_color_lut_interpolate_unit u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int used_entries(input logic [6:0] c);
    if (c == 0) return 1;
    if (c > TABLE_DEPTH) return TABLE_DEPTH;
    return int'(c);
  endfunction

  // neighbour pair and fraction for a lambda and an entry count
  function automatic void find_entries(input longint lam, input int cnt,
                                       output int lo, output int hi,
                                       output longint frac);
    longint f;
    f = lam * (cnt - 1);
    lo = int'(f >>> FRACTION_BITS);
    if (lo > cnt - 1) lo = cnt - 1;
    frac = f & ((64'd1 << FRACTION_BITS) - 1);
    hi = (lo + 1 < cnt) ? lo + 1 : lo;
  endfunction

  function automatic logic [7:0] mix_byte(input logic [7:0] lo, input logic [7:0] hi,
                                          input longint frac);
    longint acc;
    acc = ((64'd1 << FRACTION_BITS) - frac) * lo + frac * hi;
    return 8'((acc >>> FRACTION_BITS) & 255);
  endfunction

  function automatic pixel_t predict_pixel(input cmd_t cmd, input logic [31:0] sample);
    pixel_t px;
    longint one, num, den, lam, s, an, ad, q, frac;
    int lo, hi;
    one = 64'd1 << FRACTION_BITS;
    s = longint'($signed(sample));
    lam = 0;
    px.span_err = 1'b0;
    if (cmd == CMD_MAP_RAW) begin
      num = s - longint'(p_min);
      den = longint'(p_max) - longint'(p_min);
      if (den == 0) begin
        px.span_err = 1'b1;
      end else if (num != 0 && ((num < 0) == (den < 0))) begin
        an = num < 0 ? -num : num;
        ad = den < 0 ? -den : den;
        q = (an << FRACTION_BITS) / ad;
        lam = q > one ? one : q;
      end
    end else begin
      lam = s < 0 ? 0 : (s > 65536 ? 65536 : s);
      if (FRACTION_BITS >= 16) lam = lam << (FRACTION_BITS - 16);
      else lam = lam >> (16 - FRACTION_BITS);
      if (lam > one) lam = one;
    end
    if (FRACTION_BITS >= 16) px.lambda = 17'(lam >> (FRACTION_BITS - 16));
    else px.lambda = 17'(lam << (16 - FRACTION_BITS));
    find_entries(lam, used_entries(p_ccount), lo, hi, frac);
    px.red   = mix_byte(p_colors[lo][23:16], p_colors[hi][23:16], frac);
    px.green = mix_byte(p_colors[lo][15:8], p_colors[hi][15:8], frac);
    px.blue  = mix_byte(p_colors[lo][7:0], p_colors[hi][7:0], frac);
    find_entries(lam, used_entries(p_acount), lo, hi, frac);
    px.alpha = mix_byte(p_alphas[lo], p_alphas[hi], frac);
    return px;
  endfunction

  // queue building helpers
  function automatic step_t blank_step(input step_kind_t k);
    step_t st;
    st.kind = k; st.cmd = CMD_MAP_RAW; st.sample = '0; st.idx = '0;
    st.red = '0; st.green = '0; st.blue = '0; st.alpha = '0;
    st.reg_idx = '0; st.reg_data = '0;
    return st;
  endfunction

  function automatic void append_step(input step_t st);
    pending.insert(pending.size(), st);
  endfunction

  task automatic push_map(input cmd_t c, input logic [31:0] s);
    step_t st;
    st = blank_step(K_ITEM);
    st.cmd = c; st.sample = s;
    st.idx = 6'($urandom); st.red = 8'($urandom); st.green = 8'($urandom);
    st.blue = 8'($urandom); st.alpha = 8'($urandom);
    append_step(st);
  endtask

  task automatic push_load(input cmd_t c, input logic [5:0] i);
    step_t st;
    st = blank_step(K_ITEM);
    st.cmd = c; st.idx = i; st.sample = $urandom;
    st.red = 8'($urandom); st.green = 8'($urandom);
    st.blue = 8'($urandom); st.alpha = 8'($urandom);
    append_step(st);
  endtask

  task automatic push_settings(input logic [31:0] mn, input logic [31:0] mx,
                               input logic [6:0] cc, input logic [6:0] ac);
    step_t st;
    append_step(blank_step(K_DRAIN));
    st = blank_step(K_CFG);
    st.reg_idx = REG_MIN_VALUE;   st.reg_data = mn; append_step(st);
    st.reg_idx = REG_MAX_VALUE;   st.reg_data = mx; append_step(st);
    st.reg_idx = REG_COLOR_COUNT; st.reg_data = {25'($urandom), cc}; append_step(st);
    st.reg_idx = REG_ALPHA_COUNT; st.reg_data = {25'($urandom), ac}; append_step(st);
    // a write past the last register must change nothing
    st.reg_idx = CFG_IDX_W'($urandom_range(15, 4)); st.reg_data = $urandom;
    append_step(st);
  endtask

  // sample that lands inside or near the current span
  function automatic logic [31:0] near_span(input logic [31:0] mn, input logic [31:0] mx);
    longint den, t, v;
    den = longint'($signed(mx)) - longint'($signed(mn));
    t = longint'($urandom_range(70000)) - 2000;
    v = longint'($signed(mn)) + ((den * t) >>> 16);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return 32'(v);
  endfunction

  // driver: start/busy transfers and configuration writes
  always @(posedge clk) begin
    logic n_start, cfg_nxt, in_flight;
    step_t st;
    n_start = start;
    cfg_nxt = cfg_valid;
    if (rst_n) begin
      in_flight = (start && !busy) || (cfg_valid && cfg_ready);
      if (start && !busy) n_start = 1'b0;
      if (cfg_valid && cfg_ready) cfg_nxt = 1'b0;
      if (!n_start && !cfg_nxt && pending.size() != 0) begin
        st = pending[0];
        if (st.kind == K_ITEM) begin
          if ((driven >= 600 && driven < 900) || $urandom_range(99) >= 36) begin
            st = pending.pop_front();
            driven++;
            n_start = 1'b1;
            in_command <= st.cmd; in_sample <= st.sample; in_entry_index <= st.idx;
            in_red <= st.red; in_green <= st.green; in_blue <= st.blue;
            in_alpha <= st.alpha;
          end
        end else if (!in_flight && quiet >= QUIET_NEED) begin
          st = pending.pop_front();
          if (st.kind == K_CFG) begin
            cfg_nxt = 1'b1;
            cfg_index <= st.reg_idx;
            cfg_data <= st.reg_data;
          end
        end
      end
    end
    start <= n_start;
    cfg_valid <= cfg_nxt;
  end

  // monitor: tracks loads and register writes, predicts each map and checks each result
  always @(posedge clk) begin
    pixel_t exp_px, got;
    logic active;
    if (rst_n) begin
      active = 1'b0;
      if (cfg_valid && cfg_ready) begin
        active = 1'b1;
        n_cfg++;
        case (cfg_index)
          REG_MIN_VALUE:   p_min = cfg_data;
          REG_MAX_VALUE:   p_max = cfg_data;
          REG_COLOR_COUNT: p_ccount = cfg_data[6:0];
          REG_ALPHA_COUNT: p_acount = cfg_data[6:0];
          default: ;
        endcase
      end
      if (out_valid) begin
        active = 1'b1;
        got = {out_red, out_green, out_blue, out_alpha, out_lambda_out, out_span_error};
        if (pixels_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
        end else begin
          exp_px = pixels_due.pop_front();
          if (got.red !== exp_px.red)
            $display("%0t: red expected %h actual %h", $time, exp_px.red, got.red);
          if (got.green !== exp_px.green)
            $display("%0t: green expected %h actual %h", $time, exp_px.green, got.green);
          if (got.blue !== exp_px.blue)
            $display("%0t: blue expected %h actual %h", $time, exp_px.blue, got.blue);
          if (got.alpha !== exp_px.alpha)
            $display("%0t: alpha expected %h actual %h", $time, exp_px.alpha, got.alpha);
          if (got.lambda !== exp_px.lambda)
            $display("%0t: lambda expected %h actual %h", $time, exp_px.lambda, got.lambda);
          if (got.span_err !== exp_px.span_err)
            $display("%0t: span error expected %b actual %b", $time,
                     exp_px.span_err, got.span_err);
          if (got !== exp_px) errors++;
        end
      end
      if (start && !busy) begin
        active = 1'b1;
        case (cmd_t'(in_command))
          CMD_WR_COLOR: begin
            p_colors[in_entry_index] = {in_red, in_green, in_blue};
            n_loads++;
          end
          CMD_WR_ALPHA: begin
            p_alphas[in_entry_index] = in_alpha;
            n_loads++;
          end
          default: begin
            exp_px = predict_pixel(cmd_t'(in_command), in_sample);
            pixels_due.insert(pixels_due.size(), exp_px);
            n_maps++;
            if (exp_px.span_err) n_span++;
          end
        endcase
      end
      quiet = (active || pixels_due.size() != 0) ? 0 : quiet + 1;
      stall = active ? 0 : stall + 1;
      if (stall >= WATCHDOG) begin
        $display("watchdog expired at %0t", $time);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    logic [31:0] mn, mx;
    int k, ph;
    // fill every table entry so nothing unwritten is ever read
    for (k = 0; k < TABLE_DEPTH; k++) begin
      push_load(CMD_WR_COLOR, 6'(k));
      push_load(CMD_WR_ALPHA, 6'(k));
    end
    // directed: reset settings, field extremes, both map modes
    push_map(CMD_MAP_RAW, 32'h8000_0000); push_map(CMD_MAP_RAW, 32'h7FFF_FFFF);
    push_map(CMD_MAP_RAW, 32'd0);         push_map(CMD_MAP_RAW, 32'd65536);
    push_map(CMD_MAP_RAW, 32'd32768);     push_map(CMD_MAP_NORM, 32'hFFFF_FFFF);
    push_map(CMD_MAP_NORM, 32'd65536);    push_map(CMD_MAP_NORM, 32'd70000);
    push_map(CMD_MAP_NORM, 32'd12345);
    // full range and full tables, upper neighbour at the last entry
    push_settings(32'h8000_0000, 32'h7FFF_FFFF, 7'd64, 7'd64);
    push_map(CMD_MAP_RAW, 32'h7FFF_FFFF); push_map(CMD_MAP_RAW, 32'h8000_0000);
    push_map(CMD_MAP_NORM, 32'd65535);    push_map(CMD_MAP_NORM, 32'd65536);
    // zero span
    push_settings(32'd65536, 32'd65536, 7'd2, 7'd3);
    push_map(CMD_MAP_RAW, 32'd65536);     push_map(CMD_MAP_NORM, 32'd40000);
    // reversed span
    push_settings(32'd100000, -32'sd100000, 7'd17, 7'd64);
    push_map(CMD_MAP_RAW, 32'd0);         push_map(CMD_MAP_RAW, -32'sd100000);
    push_map(CMD_MAP_RAW, 32'd200000);
    // counts out of range
    push_settings(32'd0, 32'd65536, 7'd0, 7'd127);
    push_map(CMD_MAP_NORM, 32'd30000);    push_map(CMD_MAP_NORM, 32'd65536);
    // random phases
    for (ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin mn = $urandom; mx = $urandom; end
        1: begin mn = $urandom_range(200000) - 100000; mx = mn + $urandom_range(400000); end
        2: begin mn = 32'h8000_0000; mx = 32'h7FFF_FFFF; end
        default: begin mn = $urandom_range(9000); mx = mn + $urandom_range(3); end
      endcase
      push_settings(mn, mx, 7'($urandom_range(ph == 3 ? 127 : 64)),
                    7'($urandom_range(ph == 5 ? 127 : 64)));
      for (k = 0; k < 188; k++) begin
        case ($urandom_range(99) / 10)
          0: push_load(CMD_WR_COLOR, 6'($urandom));
          1: push_load(CMD_WR_ALPHA, 6'($urandom));
          2: push_map(CMD_MAP_RAW, $urandom);
          3, 4: push_map(CMD_MAP_NORM, $urandom_range(70000) - 2000);
          5: push_map(CMD_MAP_NORM, $urandom);
          default: push_map(CMD_MAP_RAW, near_span(mn, mx));
        endcase
        // hold off now and then until every result is back
        if (k == 100) append_step(blank_step(K_DRAIN));
      end
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending.size() == 0 && !start && !cfg_valid);
    wait (pixels_due.size() == 0 && quiet >= QUIET_NEED);
    $display("covered %0d maps (%0d with zero span), %0d table loads, %0d register writes",
             n_maps, n_span, n_loads, n_cfg);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
